@@ hw/rtl/dhcp_option_extractor_unit_macros.svh @@
// Assertion helpers for the DHCP option extractor.
`ifndef DHCP_OPTION_EXTRACTOR_UNIT_MACROS_SVH
`define DHCP_OPTION_EXTRACTOR_UNIT_MACROS_SVH

// Checked on every clock edge outside reset.
`define DOX_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define DOX_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ hw/rtl/dox_pkg.sv @@
package dox_pkg;

    // Magic cookie that opens the options field
    localparam logic [7:0] COOKIE_0 = 8'd99;
    localparam logic [7:0] COOKIE_1 = 8'd130;
    localparam logic [7:0] COOKIE_2 = 8'd83;
    localparam logic [7:0] COOKIE_3 = 8'd99;

    // Option codes
    localparam logic [7:0] OPT_PAD     = 8'd0;
    localparam logic [7:0] OPT_SUBNET  = 8'd1;
    localparam logic [7:0] OPT_GATEWAY = 8'd3;
    localparam logic [7:0] OPT_DNS     = 8'd6;
    localparam logic [7:0] OPT_END     = 8'd255;

    // Result status codes
    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_BAD_COOKIE = 2'd1;
    localparam logic [1:0] STATUS_TRUNCATED  = 2'd2;

    // Parser phase, one-hot
    typedef enum logic [3:0] {
        PH_COOKIE = 4'b0001,
        PH_CODE   = 4'b0010,
        PH_LEN    = 4'b0100,
        PH_VALUE  = 4'b1000
    } t_phase;

    function automatic logic [7:0] cookie_byte(input logic [1:0] idx);
        logic [7:0] res;
        unique case (idx)
            2'd0:    res = COOKIE_0;
            2'd1:    res = COOKIE_1;
            2'd2:    res = COOKIE_2;
            default: res = COOKIE_3;
        endcase
        return res;
    endfunction

endpackage

@@ hw/rtl/dhcp_option_extractor_unit.sv @@
// DHCP options parser. Takes one byte of the options field per transfer and
// accepts a new byte every cycle. A byte is captured in an input register,
// parsed against the stored parse state while held there, and any result
// lands in the output register. The input side stalls only while a result
// is held in the output register and not taken. One result per message:
// at the end option (status 0), at the first wrong cookie byte (status 1),
// or at a byte marked final before the end option (status 2). Options 1,
// 3 and 6 give the mask, gateway and DNS fields (first four value bytes,
// first byte most significant, short values zero-filled, 0 if absent). A
// byte marked first restarts the parser and clears the captured addresses;
// after a result, bytes are dropped until the next first mark.
`include "dhcp_option_extractor_unit_macros.svh"

module dhcp_option_extractor_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_first_byte,
    input  logic        i_final_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [31:0] o_subnet_mask,
    output logic [31:0] o_gateway_addr,
    output logic [31:0] o_dns_addr
);
    import dox_pkg::*;

    // Input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_first;
    logic       r_in_final;

    // Parse state
    t_phase      r_phase,     n_phase;
    logic [1:0]  r_cookie_idx, n_cookie_idx;
    logic [7:0]  r_code,      n_code;
    logic [7:0]  r_left,      n_left;
    logic [2:0]  r_vcount,    n_vcount;
    logic [31:0] r_vshift,    n_vshift;
    logic [31:0] r_mask,      n_mask;
    logic [31:0] r_gw,        n_gw;
    logic [31:0] r_dns,       n_dns;
    logic        r_done,      n_done;

    // Result register
    logic        r_out_valid;
    logic [1:0]  r_status,    n_status;
    logic [31:0] r_res_mask;
    logic [31:0] r_res_gw;
    logic [31:0] r_res_dns;
    logic        res_emit;

    logic proc;

    // Parse the held byte when the result register can take a result
    assign proc       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || proc;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_in_byte  <= i_data_byte;
            r_in_first <= i_first_byte;
            r_in_final <= i_final_byte;
        end
    end

    // Parse step for one byte
    always_comb begin
        logic [7:0]  b;
        logic [31:0] cap;
        logic        captured;
        logic        store;
        logic [4:0]  sh;
        b = r_in_byte;
        cap = '0;
        captured = 1'b0;
        store = 1'b0;
        sh = '0;

        // A first mark restarts from the reset state
        if (r_in_first) begin
            n_phase      = PH_COOKIE;
            n_cookie_idx = '0;
            n_code       = '0;
            n_left       = '0;
            n_vcount     = '0;
            n_vshift     = '0;
            n_mask       = '0;
            n_gw         = '0;
            n_dns        = '0;
            n_done       = 1'b0;
        end else begin
            n_phase      = r_phase;
            n_cookie_idx = r_cookie_idx;
            n_code       = r_code;
            n_left       = r_left;
            n_vcount     = r_vcount;
            n_vshift     = r_vshift;
            n_mask       = r_mask;
            n_gw         = r_gw;
            n_dns        = r_dns;
            n_done       = r_done;
        end

        res_emit = 1'b0;
        n_status = STATUS_TRUNCATED;
        captured = (n_code == OPT_SUBNET) || (n_code == OPT_GATEWAY) || (n_code == OPT_DNS);

        if (!n_done) begin
            unique case (n_phase)
                PH_COOKIE: begin
                    if (b != cookie_byte(n_cookie_idx)) begin
                        res_emit = 1'b1;
                        n_status = STATUS_BAD_COOKIE;
                    end else if (n_cookie_idx == 2'd3) begin
                        n_cookie_idx = '0;
                        n_phase      = PH_CODE;
                    end else begin
                        n_cookie_idx = n_cookie_idx + 2'd1;
                    end
                end
                PH_CODE: begin
                    if (b == OPT_END) begin
                        res_emit = 1'b1;
                        n_status = STATUS_OK;
                    end else if (b != OPT_PAD) begin
                        n_code  = b;
                        n_phase = PH_LEN;
                    end
                end
                PH_LEN: begin
                    n_left   = b;
                    n_vcount = '0;
                    n_vshift = '0;
                    cap      = '0;
                    store    = 1'b1;
                    n_phase  = (b == 8'd0) ? PH_CODE : PH_VALUE;
                end
                PH_VALUE: begin
                    if (n_vcount < 3'd4) begin
                        // Left-justify the bytes taken so far
                        sh       = {(2'd3 - n_vcount[1:0]), 3'b000};
                        n_vshift = {n_vshift[23:0], b};
                        n_vcount = n_vcount + 3'd1;
                        cap      = n_vshift << sh;
                        store    = 1'b1;
                    end
                    n_left = n_left - 8'd1;
                    if (n_left == 8'd0) begin
                        n_phase = PH_CODE;
                    end
                end
                default: begin
                    n_phase = PH_COOKIE;
                end
            endcase

            // Length and value bytes write the matching address register
            if (captured && store) begin
                unique case (n_code)
                    OPT_SUBNET:  n_mask = cap;
                    OPT_GATEWAY: n_gw   = cap;
                    default:     n_dns  = cap;
                endcase
            end

            // A final mark closes the message if nothing else did
            if (!res_emit && r_in_final) begin
                res_emit = 1'b1;
                n_status = STATUS_TRUNCATED;
            end
            if (res_emit) begin
                n_done = 1'b1;
            end
        end
    end

    // Parse state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_COOKIE;
            r_cookie_idx <= '0;
            r_code       <= '0;
            r_left       <= '0;
            r_vcount     <= '0;
            r_vshift     <= '0;
            r_mask       <= '0;
            r_gw         <= '0;
            r_dns        <= '0;
            r_done       <= 1'b0;
        end else if (proc) begin
            r_phase      <= n_phase;
            r_cookie_idx <= n_cookie_idx;
            r_code       <= n_code;
            r_left       <= n_left;
            r_vcount     <= n_vcount;
            r_vshift     <= n_vshift;
            r_mask       <= n_mask;
            r_gw         <= n_gw;
            r_dns        <= n_dns;
            r_done       <= n_done;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc && res_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (proc && res_emit) begin
            r_status   <= n_status;
            r_res_mask <= n_mask;
            r_res_gw   <= n_gw;
            r_res_dns  <= n_dns;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_subnet_mask  = r_res_mask;
    assign o_gateway_addr = r_res_gw;
    assign o_dns_addr     = r_res_dns;

    // Every result sets the done flag
    `DOX_ASSERT(a_emit_sets_done, (proc && res_emit) |=> r_done, "result without done flag")
    // Once done, bytes without a first mark give nothing
    `DOX_ASSERT(a_done_silent, (proc && r_done && !r_in_first) |-> !res_emit, "result after message closed")
    // The held byte waits only on a full, untaken result register
    `DOX_ASSERT(a_stall_cause, (r_in_valid && !proc) |-> (r_out_valid && !i_out_ready), "input stalled without cause")
    // No result is pending right after reset
    `DOX_ASSERT_ALWAYS(a_reset_clear, !i_rst_n |=> !r_out_valid, "result valid after reset")

endmodule
